/* rtl/btbf_pkg.sv */
// ----------------------------------------------------------------------------
// btbf_pkg: shared types and constants of the pairwise strength fit core
// widths of the divider and multiplier requests, opcodes, register indexes
// ----------------------------------------------------------------------------
package btbf_pkg;

  localparam int MAX_ENTRANTS_DEF = 32;

  // divider operand widths
  localparam int NUM_W = 79;
  localparam int DEN_W = 63;

  // gradient step operand widths
  localparam int LR_W = 23;
  localparam int SW   = 32;

  localparam int WT_W  = 40;
  localparam int TOT_W = 47;
  localparam int CFG_W = 23;

  localparam logic [DEN_W-1:0] SAT62   = 63'h4000_0000_0000_0000;
  localparam logic [DEN_W-1:0] SAT32   = 63'h0000_0000_FFFF_FFFF;
  localparam logic [SW-1:0]    ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIT   = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_ENTRANT_COUNT  = 3'd0,
    CFG_ANCHOR         = 3'd1,
    CFG_ITER_LIMIT     = 3'd2,
    CFG_CONV_THRESHOLD = 3'd3,
    CFG_PRIOR          = 3'd4,
    CFG_FIT_METHOD     = 3'd5,
    CFG_LEARNING_RATE  = 3'd6,
    CFG_FLOOR          = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] cap;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DEN_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [LR_W-1:0]  lr;
    logic [SW-1:0]    s;
    logic [DEN_W-1:0] g;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] delta;
  } mul_rsp_t;

  // 32-bit count plus increment, saturating
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [18:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {14'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* rtl/btbf_div.sv */
// ----------------------------------------------------------------------------
// btbf_div: shared restoring divider
// one quotient bit per cycle, result saturated at the requested cap
// ----------------------------------------------------------------------------
module btbf_div (
  input  logic               clk,
  input  logic               rst,
  input  btbf_pkg::div_req_t req,
  output btbf_pkg::div_rsp_t rsp
);
  import btbf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          state;
  logic [NUM_W-1:0] dvd;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] cap;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem, dvd[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            den <= req.den;
            cap <= req.cap;
            dvd <= req.num;
            rem <= '0;
            quo <= '0;
            cnt <= CNT_W'(NUM_W);
            if (req.den == '0) begin
              // division by zero gives the cap
              rsp.quo  <= req.cap;
              rsp.done <= 1'b1;
            end else begin
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], ge};
          dvd <= {dvd[NUM_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) state <= D_FIN;
        end
        D_FIN: begin
          rsp.quo  <= (quo > NUM_W'(cap)) ? cap : quo[DEN_W-1:0];
          rsp.done <= 1'b1;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/btbf_mul.sv */
// ----------------------------------------------------------------------------
// btbf_mul: gradient step multiplier
// floor(lr * s * g / 2^48) saturated to 32 bits, over five passes of one 32x32 multiplier
// ----------------------------------------------------------------------------
module btbf_mul (
  input  logic               clk,
  input  logic               rst,
  input  btbf_pkg::mul_req_t req,
  output btbf_pkg::mul_rsp_t rsp
);
  import btbf_pkg::*;

  localparam int A_W   = LR_W + SW;
  localparam int ACC_W = A_W + DEN_W;

  typedef enum logic [1:0] {M_IDLE, M_PROD, M_ACC} mstate_t;

  mstate_t          state;
  logic [2:0]       step;
  logic [LR_W-1:0]  lr;
  logic [SW-1:0]    s;
  logic [DEN_W-1:0] g;
  logic [A_W-1:0]   a;
  logic [63:0]      prod;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [31:0]      op_x;
  logic [31:0]      op_y;

  // operand selection per pass
  always_comb begin
    op_x = 32'(lr);
    op_y = s;
    case (step)
      3'd1: begin op_x = a[31:0];             op_y = g[31:0];             end
      3'd2: begin op_x = a[31:0];             op_y = 32'(g[DEN_W-1:32]);  end
      3'd3: begin op_x = 32'(a[A_W-1:32]);    op_y = g[31:0];             end
      3'd4: begin op_x = 32'(a[A_W-1:32]);    op_y = 32'(g[DEN_W-1:32]);  end
      default: ;
    endcase
  end

  always_comb begin
    acc_next = acc;
    case (step)
      3'd1:         acc_next = acc + ACC_W'(prod);
      3'd2, 3'd3:   acc_next = acc + (ACC_W'(prod) << 32);
      3'd4:         acc_next = acc + (ACC_W'(prod) << 64);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            lr    <= req.lr;
            s     <= req.s;
            g     <= req.g;
            step  <= 3'd0;
            state <= M_PROD;
          end
        end
        M_PROD: begin
          prod  <= op_x * op_y;
          state <= M_ACC;
        end
        M_ACC: begin
          if (step == 3'd0) begin
            a   <= prod[A_W-1:0];
            acc <= '0;
          end else begin
            acc <= acc_next;
          end
          if (step == 3'd4) begin
            rsp.delta <= (|acc_next[ACC_W-1:80]) ? 32'hFFFF_FFFF : acc_next[79:48];
            rsp.done  <= 1'b1;
            state     <= M_IDLE;
          end else begin
            step  <= step + 3'd1;
            state <= M_PROD;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bradley_terry_batch_fit_core.sv */
// ----------------------------------------------------------------------------
// bradley_terry_batch_fit_core: pairwise strength fit over accumulated results
// accumulates win/game counts and fits strengths by MM or gradient ascent
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser opcode; tdata entrant ids, wins, draws
//  m_*      | out       | tdata index, strength, iterations; tlast final entrant
//  cfg_*    | in        | register writes, one per cycle when cfg_we is high
//
//  an add transaction does two read-modify-write passes on both count memories
//  a clear zeroes every word of both count memories (one word a cycle)
//  after reset the same sweep runs before the first transaction is accepted
//  a fit runs every division of each iteration on the shared bit-serial divider
//  emitting holds while m_tready is low; no input is taken until the fit is done
// ----------------------------------------------------------------------------
module bradley_terry_batch_fit_core #(
  parameter int MAX_ENTRANTS = btbf_pkg::MAX_ENTRANTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,  // first_entrant, second_entrant,
                                                // first_wins, second_wins, draw_count
  input  logic [1:0]                  s_tuser,  // opcode
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [55:0]                 m_tdata,  // entrant_index, strength, iterations_run
  output logic                        m_tlast,
  // configuration
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [btbf_pkg::CFG_W-1:0]  cfg_data
);
  import btbf_pkg::*;

  localparam int IW    = $clog2(MAX_ENTRANTS);
  localparam int CA_W  = 2 * IW;
  localparam int CDEPTH = 1 << CA_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ADD0, S_ADD1, S_ADD2,
    F_WT_ADDR, F_WT_ACC, F_WT_END, F_IT_TOP,
    F_I_RD, F_I_GET, F_J_RD, F_J_GET, F_J_DIV,
    F_UPD, F_MM_DIV, F_GA_A, F_GA_G, F_GA_MUL, F_FLOOR,
    F_NORM_TOP, F_NORM_SA, F_NORM_RD, F_NORM_DIV0, F_NORM_DIV,
    F_CMP_RD, F_CMP, F_IT_END, F_EM_RD, F_EM_OUT, F_EM_WAIT
  } state_t;

  state_t state;

  // configuration registers
  logic [5:0]       entrant_count;
  logic [5:0]       anchor_entrant;
  logic [15:0]      iteration_limit;
  logic [15:0]      converge_threshold;
  logic [15:0]      prior_half_games;
  logic             fit_method;
  logic [LR_W-1:0]  learning_rate;
  logic [15:0]      strength_floor;

  // count memories
  logic [31:0]      win_mem  [CDEPTH];
  logic [31:0]      game_mem [CDEPTH];
  logic [31:0]      win_rd, game_rd;
  logic [CA_W-1:0]  cnt_raddr, cnt_waddr;
  logic             cnt_we;
  logic [31:0]      win_wd, game_wd;

  // strengths, scratch strengths and win totals
  logic [SW-1:0]    str_mem  [MAX_ENTRANTS];
  logic [MAX_ENTRANTS-1:0] str_vld;
  logic [SW-1:0]    str_rd;
  logic             str_vld_rd;
  logic [IW-1:0]    str_raddr;
  logic             str_we;

  logic [SW-1:0]    nxt_mem [MAX_ENTRANTS];
  logic [SW-1:0]    nxt_rd;
  logic [IW-1:0]    nxt_raddr;
  logic             nxt_we;
  logic [SW-1:0]    nxt_wd;

  logic [WT_W-1:0]  wt_mem [MAX_ENTRANTS];
  logic [WT_W-1:0]  wt_rd;
  logic             wt_we;

  // add transaction fields
  logic [IW-1:0]    ad_i, ad_j;
  logic [18:0]      vw1, vw2, vg;
  logic [CA_W-1:0]  sweep;

  // fit datapath
  logic [IW:0]      i, j, n;
  logic [WT_W-1:0]  w;
  logic [TOT_W-1:0] total;
  logic [15:0]      iters;
  logic [SW-1:0]    si, nv, sa, maxc;
  logic [DEN_W-1:0] d;
  logic [WT_W-1:0]  wi;
  logic             up;

  div_req_t         dreq;
  div_rsp_t         drsp;
  mul_req_t         mreq;
  mul_rsp_t         mrsp;

  // output register
  logic [4:0]       out_idx;
  logic [SW-1:0]    out_str;
  logic [15:0]      out_iters;

  // derived values
  logic [6:0]       ec_ext;
  logic             anchored, prior;
  logic [IW-1:0]    anc;
  logic             i_anc, j_anc, i_last;
  logic [WT_W-1:0]  w_new;
  logic [32:0]      g_eff;
  logic [SW:0]      den_ij;
  logic [63:0]      dsum;
  logic [DEN_W-1:0] mag;
  logic [SW:0]      up_sum;
  logic [SW-1:0]    ga_nv;
  logic [SW-1:0]    fl;
  logic [SW-1:0]    nv_f;
  logic [SW-1:0]    cmp_b, cmp_c;
  logic [SW-1:0]    emit_str;

  assign ec_ext   = {1'b0, entrant_count};
  assign n        = (ec_ext > 7'(MAX_ENTRANTS)) ? (IW+1)'(MAX_ENTRANTS) : (IW+1)'(ec_ext);
  assign anchored = {1'b0, anchor_entrant} < 7'(n);
  assign prior    = anchored && (prior_half_games != 16'd0);
  assign anc      = IW'(anchor_entrant);
  assign i_anc    = 7'(i) == {1'b0, anchor_entrant};
  assign j_anc    = 7'(j) == {1'b0, anchor_entrant};
  assign i_last   = (i + 1'b1) == n;

  // win total with prior wins against the anchor
  assign w_new  = w + WT_W'(win_rd)
                + ((prior && (i != j) && (i_anc || j_anc)) ? WT_W'(prior_half_games) : '0);
  // game count with prior games against the anchor, both directions
  assign g_eff  = {1'b0, game_rd}
                + ((prior && (i_anc || j_anc)) ? {16'b0, prior_half_games, 1'b0} : 33'd0);
  assign den_ij = {1'b0, si} + {1'b0, str_vld_rd ? str_rd : ONE_Q16};
  assign dsum   = {1'b0, d} + {1'b0, drsp.quo};
  assign mag    = (drsp.quo >= d) ? (drsp.quo - d) : (d - drsp.quo);
  assign up_sum = {1'b0, si} + {1'b0, mrsp.delta};
  assign ga_nv  = up ? (up_sum[SW] ? 32'hFFFF_FFFF : up_sum[SW-1:0])
                     : ((mrsp.delta >= si) ? '0 : (si - mrsp.delta));
  assign fl     = (strength_floor == 16'd0) ? 32'd1 : {16'b0, strength_floor};
  assign nv_f   = (nv < fl) ? fl : nv;
  assign cmp_b  = str_vld_rd ? str_rd : ONE_Q16;
  assign cmp_c  = (nxt_rd > cmp_b) ? (nxt_rd - cmp_b) : (cmp_b - nxt_rd);
  assign emit_str = str_vld_rd ? str_rd : ONE_Q16;

  // shared units
  btbf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  btbf_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  // divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    dreq.cap   = SAT62;
    case (state)
      F_J_GET: begin
        dreq.start = g_eff != 33'd0;
        dreq.num   = NUM_W'(g_eff) << 32;
        dreq.den   = DEN_W'(den_ij);
      end
      F_UPD: begin
        dreq.start = (fit_method == 1'b1) || (d != '0);
        dreq.num   = NUM_W'(wi) << 32;
        dreq.den   = fit_method ? DEN_W'(si) : d;
        dreq.cap   = fit_method ? SAT62 : SAT32;
      end
      F_GA_A: begin
        dreq.start = drsp.done;
        dreq.num   = NUM_W'(mag) << 16;
        dreq.den   = DEN_W'(total);
      end
      F_NORM_DIV0: begin
        dreq.start = 1'b1;
        dreq.num   = NUM_W'(nxt_rd) << 16;
        dreq.den   = DEN_W'(sa);
        dreq.cap   = SAT32;
      end
      default: ;
    endcase
  end

  always_comb begin
    mreq.start = (state == F_GA_G) && drsp.done;
    mreq.lr    = learning_rate;
    mreq.s     = si;
    mreq.g     = drsp.quo;
  end

  // memory ports
  always_comb begin
    cnt_raddr = {i[IW-1:0], j[IW-1:0]};
    cnt_waddr = {ad_i, ad_j};
    cnt_we    = 1'b0;
    win_wd    = '0;
    game_wd   = '0;
    str_raddr = i[IW-1:0];
    str_we    = 1'b0;
    nxt_raddr = i[IW-1:0];
    nxt_we    = 1'b0;
    nxt_wd    = nv_f;
    wt_we     = 1'b0;
    case (state)
      S_CLEAR: begin
        cnt_waddr = sweep;
        cnt_we    = 1'b1;
      end
      S_ADD0: cnt_raddr = {ad_i, ad_j};
      S_ADD1: begin
        cnt_raddr = {ad_j, ad_i};
        cnt_we    = 1'b1;
        win_wd    = sat_add32(win_rd, vw1);
        game_wd   = sat_add32(game_rd, vg);
      end
      S_ADD2: begin
        cnt_waddr = {ad_j, ad_i};
        cnt_we    = 1'b1;
        win_wd    = sat_add32(win_rd, vw2);
        game_wd   = sat_add32(game_rd, vg);
      end
      F_WT_ACC: wt_we = i != j ? (j + 1'b1) == n : (j + 1'b1) == n;
      F_J_RD:   str_raddr = j[IW-1:0];
      F_FLOOR:  nxt_we = 1'b1;
      F_NORM_TOP: nxt_raddr = anc;
      F_NORM_DIV: begin
        nxt_we = drsp.done;
        nxt_wd = drsp.quo[SW-1:0];
      end
      F_CMP:    str_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      win_mem[cnt_waddr]  <= win_wd;
      game_mem[cnt_waddr] <= game_wd;
    end
    win_rd  <= win_mem[cnt_raddr];
    game_rd <= game_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (str_we) str_mem[i[IW-1:0]] <= nxt_rd;
    str_rd <= str_mem[str_raddr];
    if (nxt_we) nxt_mem[i[IW-1:0]] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_raddr];
    if (wt_we) wt_mem[i[IW-1:0]] <= w_new;
    wt_rd <= wt_mem[i[IW-1:0]];
  end

  assign s_tready = state == S_IDLE;
  assign m_tdata  = {3'b0, out_iters, out_str, out_idx};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      sweep              <= '0;
      str_vld            <= '0;
      str_vld_rd         <= 1'b0;
      m_tvalid           <= 1'b0;
      m_tlast            <= 1'b0;
      entrant_count      <= 6'd0;
      anchor_entrant     <= 6'd32;
      iteration_limit    <= 16'd1000;
      converge_threshold <= 16'd7;
      prior_half_games   <= 16'd0;
      fit_method         <= 1'b0;
      learning_rate      <= LR_W'(65536);
      strength_floor     <= 16'd1;
    end else begin
      str_vld_rd <= str_vld[str_raddr];

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENTRANT_COUNT:  entrant_count      <= cfg_data[5:0];
          CFG_ANCHOR:         anchor_entrant     <= cfg_data[5:0];
          CFG_ITER_LIMIT:     iteration_limit    <= cfg_data[15:0];
          CFG_CONV_THRESHOLD: converge_threshold <= cfg_data[15:0];
          CFG_PRIOR:          prior_half_games   <= cfg_data[15:0];
          CFG_FIT_METHOD:     fit_method         <= cfg_data[0];
          CFG_LEARNING_RATE:  learning_rate      <= cfg_data[LR_W-1:0];
          CFG_FLOOR:          strength_floor     <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            case (opcode_t'(s_tuser))
              OP_ADD: begin
                ad_i <= IW'(s_tdata[7:0]);
                ad_j <= IW'(s_tdata[15:8]);
                vw1  <= {2'b0, s_tdata[31:16], 1'b0} + {3'b0, s_tdata[63:48]};
                vw2  <= {2'b0, s_tdata[47:32], 1'b0} + {3'b0, s_tdata[63:48]};
                vg   <= {({2'b0, s_tdata[31:16]} + {2'b0, s_tdata[47:32]}
                         + {2'b0, s_tdata[63:48]}), 1'b0};
                // out-of-range or equal ids are dropped
                if ((s_tdata[7:0] < 8'(MAX_ENTRANTS)) && (s_tdata[15:8] < 8'(MAX_ENTRANTS))
                    && (s_tdata[7:0] != s_tdata[15:8]))
                  state <= S_ADD0;
              end
              OP_FIT: begin
                i     <= '0;
                j     <= '0;
                w     <= '0;
                total <= '0;
                if (n != '0) state <= F_WT_ADDR;
              end
              OP_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_ADD0: state <= S_ADD1;
        S_ADD1: state <= S_ADD2;
        S_ADD2: state <= S_IDLE;

        // win totals per entrant
        F_WT_ADDR: state <= F_WT_ACC;
        F_WT_ACC: begin
          if ((j + 1'b1) == n) begin
            total <= total + TOT_W'(w_new);
            w     <= '0;
            j     <= '0;
            i     <= i + 1'b1;
            state <= i_last ? F_WT_END : F_WT_ADDR;
          end else begin
            w     <= w_new;
            j     <= j + 1'b1;
            state <= F_WT_ADDR;
          end
        end
        F_WT_END: begin
          iters <= '0;
          i     <= '0;
          if (fit_method && (total == '0)) begin
            state <= F_EM_RD;
          end else begin
            // all strengths restart at 1.0
            str_vld <= '0;
            state   <= F_IT_TOP;
          end
        end
        F_IT_TOP: begin
          i    <= '0;
          maxc <= '0;
          state <= (iters >= iteration_limit) ? F_EM_RD : F_I_RD;
        end

        // per-entrant update
        F_I_RD: state <= F_I_GET;
        F_I_GET: begin
          si    <= str_vld_rd ? str_rd : ONE_Q16;
          wi    <= wt_rd;
          d     <= '0;
          j     <= '0;
          state <= F_J_RD;
        end
        F_J_RD: begin
          if (j == n) state <= F_UPD;
          else if (j == i) j <= j + 1'b1;
          else state <= F_J_GET;
        end
        F_J_GET: begin
          if (g_eff == 33'd0) begin
            j     <= j + 1'b1;
            state <= F_J_RD;
          end else begin
            state <= F_J_DIV;
          end
        end
        F_J_DIV: begin
          if (drsp.done) begin
            d     <= (dsum > 64'(SAT62)) ? SAT62 : dsum[DEN_W-1:0];
            j     <= j + 1'b1;
            state <= F_J_RD;
          end
        end
        F_UPD: begin
          if (fit_method) state <= F_GA_A;
          else if (d != '0) state <= F_MM_DIV;
          else begin
            // no games: strength kept
            nv    <= si;
            state <= F_FLOOR;
          end
        end
        F_MM_DIV: begin
          if (drsp.done) begin
            nv    <= drsp.quo[SW-1:0];
            state <= F_FLOOR;
          end
        end
        F_GA_A: begin
          if (drsp.done) begin
            up    <= drsp.quo >= d;
            state <= F_GA_G;
          end
        end
        F_GA_G:   if (drsp.done) state <= F_GA_MUL;
        F_GA_MUL: begin
          if (mrsp.done) begin
            nv    <= ga_nv;
            state <= F_FLOOR;
          end
        end
        F_FLOOR: begin
          i     <= i + 1'b1;
          state <= i_last ? F_NORM_TOP : F_I_RD;
        end

        // scale so the anchor sits at 1.0
        F_NORM_TOP: begin
          i     <= '0;
          state <= anchored ? F_NORM_SA : F_CMP_RD;
        end
        F_NORM_SA: begin
          sa    <= nxt_rd;
          state <= F_NORM_RD;
        end
        F_NORM_RD:   state <= F_NORM_DIV0;
        F_NORM_DIV0: state <= F_NORM_DIV;
        F_NORM_DIV: begin
          if (drsp.done) begin
            if (i_last) begin
              i     <= '0;
              state <= F_CMP_RD;
            end else begin
              i     <= i + 1'b1;
              state <= F_NORM_RD;
            end
          end
        end

        // commit and track the largest change
        F_CMP_RD: state <= F_CMP;
        F_CMP: begin
          str_vld[i[IW-1:0]] <= 1'b1;
          if (cmp_c > maxc) maxc <= cmp_c;
          i     <= i + 1'b1;
          state <= i_last ? F_IT_END : F_CMP_RD;
        end
        F_IT_END: begin
          iters <= iters + 16'd1;
          i     <= '0;
          state <= (maxc < {16'b0, converge_threshold}) ? F_EM_RD : F_IT_TOP;
        end

        // one result per entrant
        F_EM_RD:  state <= F_EM_OUT;
        F_EM_OUT: begin
          out_idx   <= 5'(i);
          out_str   <= emit_str;
          out_iters <= iters;
          m_tlast   <= i_last;
          m_tvalid  <= 1'b1;
          state     <= F_EM_WAIT;
        end
        F_EM_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            i        <= i + 1'b1;
            state    <= m_tlast ? S_IDLE : F_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* test/bradley_terry_batch_fit_core_tb.sv */
// ----------------------------------------------------------------------------
// bradley_terry_batch_fit_core_tb: self-checking bench of the strength fit core
// streams add, clear and fit transactions under random idling on both sides,
// predicts every fitted strength in fixed point and checks each output in order
// ----------------------------------------------------------------------------
module bradley_terry_batch_fit_core_tb;
  import btbf_pkg::*;

  typedef bit [63:0] u64;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] data;
  } match_item_t;

  typedef struct {
    logic [4:0]  idx;
    logic [31:0] strength;
    logic [15:0] iters;
    logic        last;
  } strength_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bradley_terry_batch_fit_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: pairwise counts, fitted strengths and registers
  bit [31:0] win_m [32][32];
  bit [31:0] game_m [32][32];
  bit [31:0] str_q [32];
  bit [5:0]  r_count, r_anchor;
  bit [15:0] r_limit, r_thr, r_prior, r_floor;
  bit        r_method;
  bit [22:0] r_lr;

  match_item_t   pending_items[$];
  strength_rec_t expected_strengths[$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;

  // floor(num * 2^shift / den) saturated at cap
  function automatic u64 frac_div(u64 num, u64 den, int shift, u64 cap);
    u64 q, r;
    if (den == 0) return cap;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int k = 0; k < shift; k++) begin
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q = q | 1;
      end else begin
        r = r << 1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic u64 mul_shr48(u64 a, u64 b, u64 cap);
    bit [127:0] p, r;
    p = {64'b0, a} * {64'b0, b};
    r = p >> 48;
    return (r > {64'b0, cap}) ? cap : r[63:0];
  endfunction

  function automatic bit [31:0] sat_acc(bit [31:0] a, u64 v);
    u64 s;
    s = {32'b0, a} + v;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // count seen by the fit, with prior wins or games against the anchor folded in
  function automatic u64 fit_count(bit is_game, int i, int j, bit prior);
    u64 v;
    v = is_game ? game_m[i][j] : win_m[i][j];
    if (prior && i != j && (i == r_anchor || j == r_anchor))
      v += is_game ? 2 * u64'(r_prior) : u64'(r_prior);
    return v;
  endfunction

  // runs one fit over n entrants and queues the strength records it emits
  task automatic predict_fit(int n);
    bit anchored, prior, stop;
    u64 total, d, s, nv, a, mag, g32, delta, g, sa;
    u64 wt [32];
    bit [31:0] nxt [32];
    bit [31:0] fl, maxc, c;
    int iters;
    strength_rec_t rec;
    anchored = r_anchor < n;
    prior = r_prior > 0 && anchored;
    fl = (r_floor != 0) ? r_floor : 32'd1;
    total = 0;
    iters = 0;
    for (int i = 0; i < n; i++) begin
      wt[i] = 0;
      for (int j = 0; j < n; j++) wt[i] += fit_count(1'b0, i, j, prior);
      total += wt[i];
    end
    if (!(r_method && total == 0)) begin
      for (int i = 0; i < n; i++) str_q[i] = 32'h0001_0000;
      stop = 1'b0;
      while (iters < r_limit && !stop) begin
        maxc = 0;
        for (int i = 0; i < n; i++) begin
          d = 0;
          for (int j = 0; j < n; j++) begin
            if (j == i) continue;
            g = fit_count(1'b1, i, j, prior);
            if (g == 0) continue;
            d += frac_div(g, u64'(str_q[i]) + u64'(str_q[j]), 32, 64'h4000_0000_0000_0000);
            if (d > 64'h4000_0000_0000_0000) d = 64'h4000_0000_0000_0000;
          end
          s = str_q[i];
          if (!r_method) begin
            nv = (d > 0) ? frac_div(wt[i], d, 32, 64'hFFFF_FFFF) : s;
          end else begin
            a = frac_div(wt[i], s, 32, 64'h4000_0000_0000_0000);
            mag = (a >= d) ? a - d : d - a;
            g32 = frac_div(mag, total, 16, 64'h4000_0000_0000_0000);
            delta = mul_shr48(u64'(r_lr) * s, g32, 64'hFFFF_FFFF);
            if (a >= d) nv = (s + delta > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s + delta;
            else nv = (delta >= s) ? 0 : s - delta;
          end
          if (nv < fl) nv = fl;
          nxt[i] = nv[31:0];
        end
        // renormalize so the anchor sits at exactly 1.0
        if (anchored) begin
          sa = nxt[r_anchor];
          for (int i = 0; i < n; i++) nxt[i] = frac_div(nxt[i], sa, 16, 64'hFFFF_FFFF);
        end
        for (int i = 0; i < n; i++) begin
          c = (nxt[i] > str_q[i]) ? nxt[i] - str_q[i] : str_q[i] - nxt[i];
          if (c > maxc) maxc = c;
          str_q[i] = nxt[i];
        end
        iters++;
        if (maxc < r_thr) stop = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      rec.idx = i;
      rec.strength = str_q[i];
      rec.iters = iters;
      rec.last = (i == n - 1);
      expected_strengths.push_back(rec);
    end
  endtask

  task automatic predict_item(match_item_t it);
    int i, j, n;
    u64 fw, sw, dr;
    i = it.data[7:0];
    j = it.data[15:8];
    fw = it.data[31:16];
    sw = it.data[47:32];
    dr = it.data[63:48];
    case (it.op)
      OP_ADD: begin
        if (i < 32 && j < 32 && i != j) begin
          win_m[i][j] = sat_acc(win_m[i][j], 2 * fw + dr);
          win_m[j][i] = sat_acc(win_m[j][i], 2 * sw + dr);
          game_m[i][j] = sat_acc(game_m[i][j], 2 * (fw + sw + dr));
          game_m[j][i] = sat_acc(game_m[j][i], 2 * (fw + sw + dr));
        end
      end
      OP_CLEAR: begin
        for (int a = 0; a < 32; a++)
          for (int b = 0; b < 32; b++) begin
            win_m[a][b] = 0;
            game_m[a][b] = 0;
          end
      end
      OP_FIT: begin
        n = (r_count > 32) ? 32 : r_count;
        if (n > 0) predict_fit(n);
      end
      default: ;
    endcase
  endtask

  function automatic match_item_t mk(logic [1:0] op, int first, int second,
                                     int fw, int sw, int dr);
    match_item_t it;
    it.op = op;
    it.data = {dr[15:0], sw[15:0], fw[15:0], second[7:0], first[7:0]};
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: sender side, fed from pending_items
  bit took = 1'b0;
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      took = 1'b1;
      predict_item(mk(s_tuser, 0, 0, 0, 0, 0) == mk(s_tuser, 0, 0, 0, 0, 0) ?
                   '{op: s_tuser, data: s_tdata} : '{op: s_tuser, data: s_tdata});
    end
  end

  always @(negedge clk) begin
    match_item_t it;
    if (!rst && (!s_tvalid || took)) begin
      took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= it.data;
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver side: random back-pressure on the result stream
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // monitor: every result transaction against the oldest expectation
  always @(posedge clk) begin
    strength_rec_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_strengths.size() == 0) begin
        $display("%0t unexpected result: idx %0d strength %h iters %0d last %b", $time,
                 m_tdata[4:0], m_tdata[36:5], m_tdata[52:37], m_tlast);
        failed = 1'b1;
      end else begin
        e = expected_strengths.pop_front();
        if (m_tdata[4:0] !== e.idx || m_tdata[36:5] !== e.strength ||
            m_tdata[52:37] !== e.iters || m_tlast !== e.last) begin
          $display("%0t mismatch: expected idx %0d strength %h iters %0d last %b", $time,
                   e.idx, e.strength, e.iters, e.last);
          $display("%0t           actual   idx %0d strength %h iters %0d last %b", $time,
                   m_tdata[4:0], m_tdata[36:5], m_tdata[52:37], m_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENTRANT_COUNT:  r_count = val;
      CFG_ANCHOR:         r_anchor = val;
      CFG_ITER_LIMIT:     r_limit = val;
      CFG_CONV_THRESHOLD: r_thr = val;
      CFG_PRIOR:          r_prior = val;
      CFG_FIT_METHOD:     r_method = val;
      CFG_LEARNING_RATE:  r_lr = val;
      default:            r_floor = val;
    endcase
  endtask

  task automatic set_all(int n, int anc, int lim, int thr, int pr, int meth, int lr, int fl);
    write_reg(CFG_ENTRANT_COUNT, n);
    write_reg(CFG_ANCHOR, anc);
    write_reg(CFG_ITER_LIMIT, lim);
    write_reg(CFG_CONV_THRESHOLD, thr);
    write_reg(CFG_PRIOR, pr);
    write_reg(CFG_FIT_METHOD, meth);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_FLOOR, fl);
  endtask

  // sender holds off until all results are back and the core has drained
  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_strengths.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  function automatic int pick16(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    return $urandom_range(lo, hi);
  endfunction

  // one phase of random traffic over n entrants closed by a fit
  task automatic random_traffic(int n, int cnt);
    int r, a, b;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(0, n - 1);
      b = (a + $urandom_range(1, n - 1)) % n;
      if (r < 50)
        pending_items.push_back(mk(OP_ADD, a, b, $urandom_range(0, 20),
                                   $urandom_range(0, 20), $urandom_range(0, 6)));
      else if (r < 70)
        pending_items.push_back(mk(OP_ADD, a, b, $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535)));
      else if (r < 88)
        pending_items.push_back('{op: ($urandom_range(0, 1) ? OP_ADD : 2'd3),
                                  data: {$urandom, $urandom}});
      else if (r < 92)
        pending_items.push_back(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                   $urandom));
      else
        pending_items.push_back(mk(OP_ADD, a, a, 5, 1, 1));
    end
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
  endtask

  initial begin
    int n, lr_pick;
    r_count = 0; r_anchor = 32; r_limit = 1000; r_thr = 7;
    r_prior = 0; r_method = 0; r_lr = 65536; r_floor = 1;
    for (int i = 0; i < 32; i++) str_q[i] = 32'h0001_0000;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, ignored ids, zero floor, empty counts
    set_all(3, 0, 40, 7, 0, 0, 65536, 0);
    pending_items.push_back(mk(OP_ADD, 0, 1, 3, 1, 2));
    pending_items.push_back(mk(OP_ADD, 1, 2, 5, 0, 0));
    pending_items.push_back(mk(OP_ADD, 2, 0, 0, 4, 1));
    pending_items.push_back(mk(OP_ADD, 0, 31, 65535, 65535, 65535));
    pending_items.push_back(mk(OP_ADD, 31, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_ADD, 32, 1, 7, 7, 7));
    pending_items.push_back(mk(OP_ADD, 255, 255, 65535, 65535, 65535));
    pending_items.push_back(mk(OP_ADD, 1, 1, 9, 9, 9));
    pending_items.push_back('{op: 2'd3, data: '1});
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    // no games: strengths restart at 1.0 and every one comes out at 1.0
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
    wait_idle();

    // gradient with no wins at all: stored strengths, zero iterations
    write_reg(CFG_FIT_METHOD, 1);
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
    wait_idle();

    // zero entrants: fit gives nothing
    write_reg(CFG_ENTRANT_COUNT, 0);
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
    wait_idle();

    // random phases with small sizes of two to four entrants
    for (int p = 0; p < 10; p++) begin
      no_idle = (p % 4 == 3);
      n = $urandom_range(2, 4);
      lr_pick = $urandom_range(0, 4);
      set_all(n, ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(0, n),
              $urandom_range(1, 20),
              ($urandom_range(0, 3) == 0) ? pick16(0, 65535) : $urandom_range(0, 200),
              pick16(1, 50), $urandom_range(0, 1),
              (lr_pick == 0) ? 0 : (lr_pick == 1) ? 4194304 : (lr_pick == 2) ? 8388607 :
              (lr_pick == 3) ? 65536 : $urandom_range(1, 1 << 20),
              pick16(0, 100));
      random_traffic(n, 24);
      wait_idle();
    end
    no_idle = 1'b0;

    // largest size: count above the maximum acts as the maximum, one iteration
    set_all(40, 63, 1, 7, 65535, 0, 65536, 1);
    for (int k = 0; k < 12; k++)
      pending_items.push_back(mk(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 100), $urandom_range(0, 100), 1));
    pending_items.push_back(mk(OP_FIT, 0, 0, 0, 0, 0));
    wait_idle();

    if (!failed) begin
      $display("bradley_terry_batch_fit_core_tb: PASS");
    end else begin
      $display("bradley_terry_batch_fit_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("bradley_terry_batch_fit_core_tb: FAIL");
    $finish;
  end

endmodule
